@@ design/matr_pkg.sv @@
// ----------------------------------------------------------------------------
// matr_pkg: shared types and constants of the MIDI active-note tracker
// Transaction payload structs, command and operation codes, MIDI constants.
// ----------------------------------------------------------------------------
package matr_pkg;

   localparam int DEF_CHANNELS = 16;
   localparam int DEF_NOTES    = 128;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = 2;

   localparam logic [1:0] CMD_MSG   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [1:0] LEN_ONE   = 2'd1;
   localparam logic [1:0] LEN_THREE = 2'd3;

   localparam logic [7:0] MIDI_START    = 8'hFA;
   localparam logic [7:0] MIDI_CONTINUE = 8'hFB;
   localparam logic [7:0] MIDI_STOP     = 8'hFC;

   localparam logic [7:0] KIND_MASK     = 8'hF0;
   localparam logic [7:0] KIND_NOTE_OFF = 8'h80;
   localparam logic [7:0] KIND_NOTE_ON  = 8'h90;
   localparam logic [7:0] KIND_CTRL     = 8'hB0;

   localparam logic [7:0] CC_ALL_SOUND_OFF = 8'd120;
   localparam logic [7:0] CC_ALL_NOTES_OFF = 8'd123;

   localparam logic [7:0] SRC_EXTERNAL = 8'd2;

   typedef logic [2:0] op_type;

   localparam op_type OP_NONE     = 3'd0;
   localparam op_type OP_WRITE    = 3'd1;
   localparam op_type OP_CLR_CHAN = 3'd2;
   localparam op_type OP_CLR_ALL  = 3'd3;
   localparam op_type OP_READ     = 3'd4;

   typedef struct packed {
      logic [1:0] cmd;
      logic [1:0] msg_len;
      logic [7:0] status_byte;
      logic [7:0] data_one;
      logic [7:0] data_two;
      logic [7:0] source;
      logic [3:0] read_channel;
      logic [6:0] read_note;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_velocity;
      logic [31:0] update_count;
      logic [31:0] note_event_count;
      logic [31:0] realtime_event_count;
      logic        playing;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] chan;
      logic [6:0] note;
      logic [7:0] vel;
      rsp_type    rsp;
   } entry_type;

endpackage

@@ design/matr_ram.sv @@
// ----------------------------------------------------------------------------
// matr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module matr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

@@ design/matr_front.sv @@
// ----------------------------------------------------------------------------
// matr_front: command decoder and event counters
// Accepts request transactions, classifies them into table operations and
// computes the counters and playing flag that each result reports.
// ----------------------------------------------------------------------------
module matr_front #(
   parameter int CHANNELS = matr_pkg::DEF_CHANNELS,
   parameter int NOTES    = matr_pkg::DEF_NOTES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  matr_pkg::req_type   req_data,
   input  logic                init_busy,
   input  logic                q_full,
   output logic                q_push,
   output matr_pkg::entry_type q_entry
);

   import matr_pkg::*;

   logic [31:0] gen_ff, gen_in;
   logic [31:0] note_ff, note_in;
   logic [31:0] rt_ff, rt_in;
   logic        play_ff, play_in;

   logic        accept;
   logic [7:0]  kind;
   logic        chan_ok;
   logic        note_ok;
   logic        read_ok;
   op_type      op;
   logic [7:0]  vel;

   assign full    = q_full | init_busy;
   assign accept  = push & ~full;
   assign kind    = req_data.status_byte & KIND_MASK;
   assign chan_ok = {1'b0, req_data.status_byte[3:0]} < 5'(CHANNELS);
   assign note_ok = {1'b0, req_data.data_one} < 9'(NOTES);
   assign read_ok = ({1'b0, req_data.read_channel} < 5'(CHANNELS))
                 && ({1'b0, req_data.read_note} < 8'(NOTES));

   always_comb begin
      op      = OP_NONE;
      vel     = 8'd0;
      gen_in  = gen_ff;
      note_in = note_ff;
      rt_in   = rt_ff;
      play_in = play_ff;
      case (req_data.cmd)
         CMD_MSG: begin
            if (req_data.msg_len == LEN_ONE) begin
               rt_in = rt_ff + 32'd1;
               if (req_data.status_byte inside {MIDI_START, MIDI_CONTINUE}) begin
                  play_in = 1'b1;
               end else if (req_data.status_byte == MIDI_STOP) begin
                  play_in = 1'b0;
                  op      = OP_CLR_ALL;
                  gen_in  = gen_ff + 32'd1;
               end
            end else if (req_data.msg_len == LEN_THREE && req_data.source == SRC_EXTERNAL
                         && chan_ok) begin
               if (kind == KIND_CTRL) begin
                  if (req_data.data_one inside {CC_ALL_SOUND_OFF, CC_ALL_NOTES_OFF}) begin
                     op     = OP_CLR_CHAN;
                     gen_in = gen_ff + 32'd1;
                  end
               end else if ((kind == KIND_NOTE_ON || kind == KIND_NOTE_OFF) && note_ok) begin
                  op      = OP_WRITE;
                  note_in = note_ff + 32'd1;
                  gen_in  = gen_ff + 32'd1;
                  if (kind == KIND_NOTE_ON) begin
                     vel = req_data.data_two;
                  end
               end
            end
         end
         CMD_CLEAR: begin
            op     = OP_CLR_ALL;
            gen_in = gen_ff + 32'd1;
         end
         CMD_READ: begin
            if (read_ok) begin
               op = OP_READ;
            end
         end
         default: begin
            op = OP_NONE;
         end
      endcase
   end

   always_comb begin
      q_push                            = accept;
      q_entry.op                        = op;
      q_entry.vel                       = vel;
      q_entry.chan                      = (op == OP_READ) ? req_data.read_channel
                                                          : req_data.status_byte[3:0];
      q_entry.note                      = (op == OP_READ) ? req_data.read_note
                                                          : req_data.data_one[6:0];
      q_entry.rsp.read_velocity         = 8'd0;
      q_entry.rsp.update_count          = gen_in;
      q_entry.rsp.note_event_count      = note_in;
      q_entry.rsp.realtime_event_count  = rt_in;
      q_entry.rsp.playing               = play_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff  <= 32'd0;
         note_ff <= 32'd0;
         rt_ff   <= 32'd0;
         play_ff <= 1'b0;
      end else if (accept) begin
         gen_ff  <= gen_in;
         note_ff <= note_in;
         rt_ff   <= rt_in;
         play_ff <= play_in;
      end
   end

endmodule

@@ design/matr_queue.sv @@
// ----------------------------------------------------------------------------
// matr_queue: operation queue between decoder and table engine
// Small register FIFO of decoded operations.
// ----------------------------------------------------------------------------
module matr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_push,
   input  matr_pkg::entry_type q_wr_entry,
   output logic                q_full,
   input  logic                q_pop,
   output matr_pkg::entry_type q_rd_entry,
   output logic                q_empty
);

   import matr_pkg::*;

   entry_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign q_full     = count_ff == (QPTR_W + 1)'(QUEUE_DEPTH);
   assign q_empty    = count_ff == '0;
   assign q_rd_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = q_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (q_push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!q_push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         entry_ff[wr_ptr_ff] <= q_wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ design/matr_back.sv @@
// ----------------------------------------------------------------------------
// matr_back: velocity table engine
// Executes queued operations on the velocity RAM (writes, reads, clearing
// sweeps) and holds the result register.
// ----------------------------------------------------------------------------
module matr_back #(
   parameter int CHANNELS = matr_pkg::DEF_CHANNELS,
   parameter int NOTES    = matr_pkg::DEF_NOTES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  matr_pkg::entry_type q_entry,
   output logic                q_pop,
   output logic                init_busy,
   output logic                empty,
   input  logic                pop,
   output matr_pkg::rsp_type   rsp_data
);

   import matr_pkg::*;

   localparam int DEPTH  = CHANNELS * NOTES;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CHAN_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int NOTE_W = (NOTES > 1) ? $clog2(NOTES) : 1;

   localparam logic [1:0] ST_INIT  = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;
   localparam logic [1:0] ST_READ  = 2'd3;

   logic [1:0]        st_ff, st_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] end_ff, end_in;
   entry_type         cur_ff, cur_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              slot_free;
   logic [ADDR_W-1:0] base_addr;
   logic [ADDR_W-1:0] entry_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [7:0]        rd_data;

   assign base_addr  = ADDR_W'(ADDR_W'(q_entry.chan[CHAN_W-1:0]) * ADDR_W'(NOTES));
   assign entry_addr = base_addr + ADDR_W'(q_entry.note[NOTE_W-1:0]);
   assign slot_free  = !rsp_valid_ff || pop;
   assign init_busy  = st_ff == ST_INIT;
   assign empty      = !rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   matr_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (entry_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      st_in        = st_ff;
      addr_in      = addr_ff;
      end_in       = end_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = 8'd0;
      rd_en        = 1'b0;
      case (st_ff)
         ST_INIT: begin
            wr_en = 1'b1;
            if (addr_ff == end_ff) begin
               st_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (!q_empty && slot_free) begin
               q_pop  = 1'b1;
               cur_in = q_entry;
               case (q_entry.op)
                  OP_WRITE: begin
                     wr_en        = 1'b1;
                     wr_addr      = entry_addr;
                     wr_data      = q_entry.vel;
                     rsp_valid_in = 1'b1;
                     rsp_in       = q_entry.rsp;
                  end
                  OP_CLR_CHAN: begin
                     addr_in = base_addr;
                     end_in  = base_addr + ADDR_W'(NOTES - 1);
                     st_in   = ST_SWEEP;
                  end
                  OP_CLR_ALL: begin
                     addr_in = '0;
                     end_in  = ADDR_W'(DEPTH - 1);
                     st_in   = ST_SWEEP;
                  end
                  OP_READ: begin
                     rd_en = 1'b1;
                     st_in = ST_READ;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = q_entry.rsp;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            wr_en = 1'b1;
            if (addr_ff == end_ff) begin
               st_in        = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = cur_ff.rsp;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_READ: begin
            st_in                = ST_IDLE;
            rsp_valid_in         = 1'b1;
            rsp_in               = cur_ff.rsp;
            rsp_in.read_velocity = rd_data;
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_INIT;
         addr_ff      <= '0;
         end_ff       <= ADDR_W'(DEPTH - 1);
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         addr_ff      <= addr_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_result_in_init: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_INIT |-> !rsp_valid_ff)
      else $error("result shown during clearing pass");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (st_ff == ST_IDLE && !q_empty && slot_free))
      else $error("operation taken while engine busy");

   a_sweep_in_range: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_SWEEP || st_ff == ST_INIT) |-> addr_ff <= end_ff)
      else $error("sweep address passed its end");

   a_read_delivers: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_READ |=> rsp_valid_ff)
      else $error("read did not produce a result");

endmodule

@@ design/midi_active_note_tracker.sv @@
// ----------------------------------------------------------------------------
// midi_active_note_tracker: MIDI active-note velocity table
// Tracks note velocities per channel, event counters and the playing flag.
//
//   channel   ports                      direction  handshake
//   request   push, full, req_data       in         push && !full
//   response  empty, pop, rsp_data       out        pop && !empty
//
// The decoder takes one request per cycle while full is low into a four-deep
// operation queue. The table engine does a note write or plain update in its
// idle state, a read through the registered RAM read port, and a channel or
// full clear as a sweep, one RAM write per cycle; it takes the next operation
// only when idle. After reset, full stays high for the clearing pass. A stalled
// response holds the engine; the queue keeps taking requests until it fills.
// ----------------------------------------------------------------------------
module midi_active_note_tracker #(
   parameter int CHANNELS = matr_pkg::DEF_CHANNELS,
   parameter int NOTES    = matr_pkg::DEF_NOTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  matr_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output matr_pkg::rsp_type rsp_data
);

   import matr_pkg::*;

   logic      q_push;
   logic      q_full;
   logic      q_pop;
   logic      q_empty;
   logic      init_busy;
   entry_type q_wr_entry;
   entry_type q_rd_entry;

   matr_front #(
      .CHANNELS (CHANNELS),
      .NOTES    (NOTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .init_busy (init_busy),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_wr_entry)
   );

   matr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .q_push     (q_push),
      .q_wr_entry (q_wr_entry),
      .q_full     (q_full),
      .q_pop      (q_pop),
      .q_rd_entry (q_rd_entry),
      .q_empty    (q_empty)
   );

   matr_back #(
      .CHANNELS (CHANNELS),
      .NOTES    (NOTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_entry   (q_rd_entry),
      .q_pop     (q_pop),
      .init_busy (init_busy),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ sim/midi_active_note_tracker_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_active_note_tracker_test: testbench of the MIDI active-note tracker
// A directed table of requests is replayed first, then random requests.
// Most random requests are well-formed note and control messages on a few busy
// channels and notes, with reads, realtime messages, clears and raw noise
// mixed in. Every response is compared field by field with a directed row's
// fixed values or with a velocity table kept by the testbench. Both sides idle
// at random. One long response hold fills the queue and stalls the request side.
// ----------------------------------------------------------------------------
module midi_active_note_tracker_test;
   import matr_pkg::*;

   localparam logic [1:0] CMD_NOP   = 2'd3;
   localparam logic [1:0] LEN_NONE  = 2'd0;
   localparam logic [1:0] LEN_TWO   = 2'd2;
   localparam logic [7:0] MIDI_CLOCK = 8'hF8;
   localparam int TABLE_DEPTH  = DEF_CHANNELS * DEF_NOTES;
   localparam int RANDOM_ITEMS = 1100;
   localparam int HOLD_AT      = 60;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 100;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    push;
   logic    full;
   req_type req_data;
   logic    empty;
   logic    pop;
   rsp_type rsp_data;

   logic [7:0]  vel_store [TABLE_DEPTH];
   logic [31:0] gen_count;
   logic [31:0] note_count;
   logic [31:0] rt_count;
   logic        play_now;

   rsp_type     pending_rsp [$];
   dir_row_type dir_rows [$];
   int          err_cnt;
   int          sent_cnt;
   int          got_cnt;

   midi_active_note_tracker u_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic void clear_velocities(input int first, input int count);
      for (int i = first; i < first + count; i++) begin
         vel_store[i] = 8'd0;
      end
   endfunction

   function automatic rsp_type track_command(input req_type r);
      rsp_type    o;
      logic [7:0] kind;
      int         ch;
      o = '0;
      case (r.cmd)
         CMD_MSG: begin
            kind = r.status_byte & KIND_MASK;
            ch = int'(r.status_byte[3:0]);
            if (r.msg_len == LEN_ONE) begin
               rt_count++;
               if (r.status_byte == MIDI_START || r.status_byte == MIDI_CONTINUE) begin
                  play_now = 1'b1;
               end else if (r.status_byte == MIDI_STOP) begin
                  play_now = 1'b0;
                  clear_velocities(0, TABLE_DEPTH);
                  gen_count++;
               end
            end else if (r.msg_len == LEN_THREE && r.source == SRC_EXTERNAL
                         && ch < DEF_CHANNELS) begin
               if (kind == KIND_CTRL) begin
                  if (r.data_one == CC_ALL_SOUND_OFF || r.data_one == CC_ALL_NOTES_OFF) begin
                     clear_velocities(ch * DEF_NOTES, DEF_NOTES);
                     gen_count++;
                  end
               end else if ((kind == KIND_NOTE_ON || kind == KIND_NOTE_OFF)
                            && r.data_one < DEF_NOTES) begin
                  note_count++;
                  if (kind == KIND_NOTE_ON && r.data_two != 8'd0) begin
                     vel_store[ch * DEF_NOTES + int'(r.data_one)] = r.data_two;
                  end else begin
                     vel_store[ch * DEF_NOTES + int'(r.data_one)] = 8'd0;
                  end
                  gen_count++;
               end
            end
         end
         CMD_CLEAR: begin
            clear_velocities(0, TABLE_DEPTH);
            gen_count++;
         end
         CMD_READ: begin
            if (r.read_channel < DEF_CHANNELS && r.read_note < DEF_NOTES) begin
               o.read_velocity = vel_store[int'(r.read_channel) * DEF_NOTES
                                           + int'(r.read_note)];
            end
         end
         default: begin
         end
      endcase
      o.update_count         = gen_count;
      o.note_event_count     = note_count;
      o.realtime_event_count = rt_count;
      o.playing              = play_now;
      return o;
   endfunction

   function automatic req_type make_req(input logic [1:0] cmd, input logic [1:0] len,
                                        input logic [7:0] status, input logic [7:0] d1,
                                        input logic [7:0] d2, input logic [7:0] src,
                                        input logic [3:0] rc, input logic [6:0] rn);
      req_type r;
      r.cmd          = cmd;
      r.msg_len      = len;
      r.status_byte  = status;
      r.data_one     = d1;
      r.data_two     = d2;
      r.source       = src;
      r.read_channel = rc;
      r.read_note    = rn;
      return r;
   endfunction

   function automatic rsp_type make_rsp(input logic [7:0] vel, input logic [31:0] gen,
                                        input logic [31:0] notes, input logic [31:0] rt,
                                        input logic play);
      rsp_type o;
      o.read_velocity        = vel;
      o.update_count         = gen;
      o.note_event_count     = notes;
      o.realtime_event_count = rt;
      o.playing              = play;
      return o;
   endfunction

   function automatic void add_row(input req_type r, input bit typed, input rsp_type w);
      dir_row_type row;
      row.req   = r;
      row.typed = typed;
      row.want  = w;
      dir_rows.push_back(row);
   endfunction

   function automatic logic [3:0] busy_channel();
      if ($urandom_range(0, 3) == 0) begin
         return 4'($urandom_range(0, 15));
      end
      return 4'($urandom_range(0, 2));
   endfunction

   function automatic logic [6:0] busy_note();
      if ($urandom_range(0, 3) == 0) begin
         return 7'($urandom_range(0, 127));
      end
      return 7'($urandom_range(60, 63));
   endfunction

   function automatic req_type random_request();
      req_type     r;
      logic [63:0] raw;
      int          pick;
      logic [7:0]  kind;
      raw  = {$urandom, $urandom};
      r    = raw[$bits(req_type)-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         kind = ($urandom_range(0, 9) < 7) ? KIND_NOTE_ON : KIND_NOTE_OFF;
         r.cmd         = CMD_MSG;
         r.msg_len     = LEN_THREE;
         r.source      = SRC_EXTERNAL;
         r.status_byte = kind | {4'd0, busy_channel()};
         r.data_one    = {1'b0, busy_note()};
         r.data_two    = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      end else if (pick < 70) begin
         r.cmd          = CMD_READ;
         r.read_channel = busy_channel();
         r.read_note    = busy_note();
      end else if (pick < 78) begin
         r.cmd         = CMD_MSG;
         r.msg_len     = LEN_THREE;
         r.source      = SRC_EXTERNAL;
         r.status_byte = KIND_CTRL | {4'd0, busy_channel()};
         if (pick < 74) begin
            r.data_one = $urandom_range(0, 1) ? CC_ALL_SOUND_OFF : CC_ALL_NOTES_OFF;
         end
      end else if (pick < 84) begin
         r.cmd     = CMD_MSG;
         r.msg_len = LEN_ONE;
         case ($urandom_range(0, 7))
            0:       r.status_byte = MIDI_STOP;
            1, 2:    r.status_byte = MIDI_START;
            3:       r.status_byte = MIDI_CONTINUE;
            4:       r.status_byte = MIDI_CLOCK;
            default: begin
            end
         endcase
      end else if (pick < 85) begin
         r.cmd = CMD_CLEAR;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
      err_cnt++;
   endtask

   task automatic send_request(input req_type r, input bit typed, input rsp_type want);
      int      gap;
      rsp_type pred;
      gap = ((sent_cnt / 64) % 4 == 3) ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      pred = track_command(r);
      pending_rsp.push_back(typed ? want : pred);
      sent_cnt++;
   endtask

   initial begin
      rsp_type none;
      none     = '0;
      reset    = 1'b1;
      push     = 1'b0;
      req_data = '0;
      err_cnt  = 0;
      sent_cnt = 0;
      gen_count  = '0;
      note_count = '0;
      rt_count   = '0;
      play_now   = 1'b0;
      clear_velocities(0, TABLE_DEPTH);

      add_row(make_req(CMD_READ, LEN_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 4'd0, 7'd0),
              1'b1, make_rsp(8'd0, 32'd0, 32'd0, 32'd0, 1'b0));
      add_row(make_req(CMD_READ, LEN_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 4'd15, 7'd127),
              1'b1, make_rsp(8'd0, 32'd0, 32'd0, 32'd0, 1'b0));
      add_row(make_req(CMD_NOP, LEN_THREE, 8'h90, 8'h10, 8'h7F, SRC_EXTERNAL, 4'd0, 7'd0),
              1'b1, make_rsp(8'd0, 32'd0, 32'd0, 32'd0, 1'b0));
      add_row(make_req(CMD_MSG, LEN_NONE, 8'h90, 8'h10, 8'h7F, SRC_EXTERNAL, 4'd0, 7'd0),
              1'b1, make_rsp(8'd0, 32'd0, 32'd0, 32'd0, 1'b0));
      add_row(make_req(CMD_MSG, LEN_ONE, MIDI_START, 8'h00, 8'h00, 8'h00, 4'd0, 7'd0),
              1'b1, make_rsp(8'd0, 32'd0, 32'd0, 32'd1, 1'b1));
      add_row(make_req(CMD_MSG, LEN_ONE, MIDI_CLOCK, 8'h00, 8'h00, 8'h00, 4'd0, 7'd0),
              1'b1, make_rsp(8'd0, 32'd0, 32'd0, 32'd2, 1'b1));
      add_row(make_req(CMD_MSG, LEN_ONE, MIDI_CONTINUE, 8'h00, 8'h00, 8'h00, 4'd0, 7'd0),
              1'b1, make_rsp(8'd0, 32'd0, 32'd0, 32'd3, 1'b1));
      add_row(make_req(CMD_MSG, LEN_ONE, MIDI_STOP, 8'h00, 8'h00, 8'h00, 4'd0, 7'd0),
              1'b1, make_rsp(8'd0, 32'd1, 32'd0, 32'd4, 1'b0));
      add_row(make_req(CMD_MSG, LEN_TWO, 8'h90, 8'h40, 8'h7F, SRC_EXTERNAL, 4'd0, 7'd0),
              1'b1, make_rsp(8'd0, 32'd1, 32'd0, 32'd4, 1'b0));
      add_row(make_req(CMD_MSG, LEN_THREE, 8'h90, 8'h40, 8'h7F, 8'h00, 4'd0, 7'd0),
              1'b1, make_rsp(8'd0, 32'd1, 32'd0, 32'd4, 1'b0));
      add_row(make_req(CMD_MSG, LEN_THREE, 8'h90, 8'd0, 8'hFF, SRC_EXTERNAL, 4'd0, 7'd0),
              1'b0, none);
      add_row(make_req(CMD_MSG, LEN_THREE, 8'h9F, 8'd127, 8'h01, SRC_EXTERNAL, 4'd0, 7'd0),
              1'b0, none);
      add_row(make_req(CMD_READ, LEN_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 4'd15, 7'd127),
              1'b0, none);
      add_row(make_req(CMD_READ, LEN_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 4'd0, 7'd0),
              1'b0, none);
      add_row(make_req(CMD_MSG, LEN_THREE, 8'h90, 8'd128, 8'h05, SRC_EXTERNAL, 4'd0, 7'd0),
              1'b0, none);
      add_row(make_req(CMD_MSG, LEN_THREE, 8'h90, 8'd255, 8'h05, SRC_EXTERNAL, 4'd0, 7'd0),
              1'b0, none);
      add_row(make_req(CMD_MSG, LEN_THREE, 8'h9F, 8'd127, 8'h00, SRC_EXTERNAL, 4'd0, 7'd0),
              1'b0, none);
      add_row(make_req(CMD_MSG, LEN_THREE, 8'h80, 8'd0, 8'h40, SRC_EXTERNAL, 4'd0, 7'd0),
              1'b0, none);
      add_row(make_req(CMD_MSG, LEN_THREE, 8'hA0, 8'd0, 8'h01, SRC_EXTERNAL, 4'd0, 7'd0),
              1'b0, none);
      add_row(make_req(CMD_MSG, LEN_THREE, 8'h93, 8'd64, 8'd100, SRC_EXTERNAL, 4'd0, 7'd0),
              1'b0, none);
      add_row(make_req(CMD_MSG, LEN_THREE, 8'hB3, 8'd7, 8'h00, SRC_EXTERNAL, 4'd0, 7'd0),
              1'b0, none);
      add_row(make_req(CMD_READ, LEN_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 4'd3, 7'd64),
              1'b0, none);
      add_row(make_req(CMD_MSG, LEN_THREE, 8'hB3, CC_ALL_NOTES_OFF, 8'h00, SRC_EXTERNAL,
                       4'd0, 7'd0), 1'b0, none);
      add_row(make_req(CMD_MSG, LEN_THREE, 8'hBF, CC_ALL_SOUND_OFF, 8'h00, SRC_EXTERNAL,
                       4'd0, 7'd0), 1'b0, none);
      add_row(make_req(CMD_CLEAR, LEN_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 4'd0, 7'd0),
              1'b0, none);
      add_row(make_req(CMD_READ, LEN_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 4'd3, 7'd64),
              1'b0, none);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         send_request(random_request(), 1'b0, none);
      end
      push <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_cnt == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      int      stall;
      bit      held;
      rsp_type want;
      pop     = 1'b0;
      got_cnt = 0;
      held    = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = ((got_cnt / 48) % 4 == 2) ? 0 : $urandom_range(0, 5);
         if (got_cnt == HOLD_AT && !held) begin
            held  = 1'b1;
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected transaction", 32'(rsp_data.update_count), 32'd0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.read_velocity !== want.read_velocity)
               report_mismatch("read_velocity", 32'(rsp_data.read_velocity),
                               32'(want.read_velocity));
            if (rsp_data.update_count !== want.update_count)
               report_mismatch("update_count", rsp_data.update_count, want.update_count);
            if (rsp_data.note_event_count !== want.note_event_count)
               report_mismatch("note_event_count", rsp_data.note_event_count,
                               want.note_event_count);
            if (rsp_data.realtime_event_count !== want.realtime_event_count)
               report_mismatch("realtime_event_count", rsp_data.realtime_event_count,
                               want.realtime_event_count);
            if (rsp_data.playing !== want.playing)
               report_mismatch("playing", 32'(rsp_data.playing), 32'(want.playing));
         end
         got_cnt++;
      end
   end

endmodule
